@@ hw/rtl/rars_pkg.sv @@
// Package: types and constants shared by the range add / range sum tree.
package rars_pkg;

   localparam int LEAVES     = 1024;
   localparam int LVL_W      = 10;                 // tree depth below the root
   localparam int IDX_W      = 10;                 // index field width
   localparam int NODE_W     = LVL_W + 1;          // node address width
   localparam int STACK_D    = 2 * LVL_W + 2;      // walk stack depth
   localparam int SP_W       = 5;
   localparam int SPAN_W     = IDX_W + 1;          // span length up to LEAVES

   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_SUM = 1'b1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // One memory access request from the walker to the node store.
   typedef struct packed {
      logic        rd;
      logic        wr;
      node_type    addr;
      logic [63:0] sum_wr;
      logic [63:0] tag_wr;
   } mem_req_type;

   // Multiply a tag by a span length (a 64 x 11 product).
   function automatic logic [63:0] scale(input logic [63:0] tag,
                                         input logic [SPAN_W-1:0] len);
      scale = tag * {{(64-SPAN_W){1'b0}}, len};
   endfunction

endpackage

@@ hw/rtl/rars_node_mem.sv @@
// Node memory: one synchronous RAM holding each node's sum and lazy tag.
module rars_node_mem
   import rars_pkg::*;
(
   input  logic        clock,
   input  mem_req_type req,
   output logic [63:0] sum_rd,
   output logic [63:0] tag_rd
);

   logic [127:0] mem [0:(1<<NODE_W)-1];
   logic [127:0] rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= {req.sum_wr, req.tag_wr};
      end
      if (req.rd) begin
         rd_ff <= mem[req.addr];
      end
   end

   assign sum_rd = rd_ff[127:64];
   assign tag_rd = rd_ff[63:0];

endmodule

@@ hw/rtl/range_add_range_sum_tree.sv @@
// Top level: lazy segment tree with range add and range sum over 1024 elements.
//
// Usage notes:
//  - req_ channel carries one request per transfer: req_req_type selects add
//    (REQ_ADD) or sum (REQ_SUM) over req_left..req_right, right clipped to the
//    last leaf. An add yields no rsp_ transfer; a sum yields exactly one.
//  - Node sums and lazy tags live in one 2048 x 128 synchronous RAM. The walk
//    is an explicit stack machine, one RAM access per cycle. A fully covered
//    node is read, then updated; a split node is read, checked, and its
//    children scheduled; with a pending tag it first clears its own tag and
//    reads and writes each child. Each recombine on the way back up (adds
//    only) reads both children, writes the parent; the walk ends in S_DONE.
//  - A sum over the whole array passes S_EVAL, S_POP and S_DONE before it is
//    valid and the next request can follow in that cycle; an empty range
//    goes straight from S_IDLE to S_DONE.
//  - After reset a clearing pass writes zero to all 2048 RAM rows, one per
//    cycle; req_stall is high until the pass ends.
//  - One request is walked at a time. The result sits in an output register;
//    while rsp_stall holds it, the next request may still be accepted and
//    walked, but its sum is held until the output register is free.
//  - Reset is synchronous, active high, and clears all control state.
//  - Empty ranges (left above clipped right) finish at once; a sum returns 0.
module range_add_range_sum_tree
   import rars_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_req_type,
   input  logic [9:0]  req_left,
   input  logic [9:0]  req_right,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_range_sum
);

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_POP   = 12'b000000000100,
      S_EVAL  = 12'b000000001000,
      S_PDLR  = 12'b000000010000,
      S_PDLW  = 12'b000000100000,
      S_PDRR  = 12'b000001000000,
      S_PDRW  = 12'b000010000000,
      S_SCHED = 12'b000100000000,
      S_LSUM  = 12'b001000000000,
      S_COMB  = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   // Stack frame: node, its span, and whether this is the recombine visit.
   typedef struct packed {
      logic     post;
      node_type node;
      idx_type  lo;
      idx_type  hi;
   } frame_type;

   state_type   state_ff, state_in;
   frame_type   stack_ff [0:STACK_D-1];
   logic [SP_W-1:0] sp_ff, sp_in;
   frame_type   cur_ff, cur_in;
   node_type    clr_ff, clr_in;
   logic        kind_ff;
   idx_type     l_ff, r_ff;
   logic [63:0] val_ff;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] tag_ff, tag_in;        // parent tag being pushed down
   logic [63:0] lsum_ff, lsum_in;      // left child sum for recombine
   logic        out_v_ff, out_v_in;
   logic [63:0] out_ff, out_in;

   mem_req_type mreq;
   logic [63:0] sum_rd, tag_rd;

   rars_node_mem u_mem (
      .clock  (clock),
      .req    (mreq),
      .sum_rd (sum_rd),
      .tag_rd (tag_rd)
   );

   idx_type     mid;
   logic        covered;
   logic        push_l, push_r;
   logic        n_post;
   logic [SPAN_W-1:0] len_l, len_r, len_all;
   idx_type     r_clip;
   logic        accept;
   logic        load_out;
   node_type    lchild, rchild;
   frame_type   top, fl, fr, fpost;
   logic [SP_W-1:0] sp_right, sp_left;

   assign r_clip  = req_right;          // LEAVES equals the index range
   assign mid     = cur_ff.lo + ((cur_ff.hi - cur_ff.lo) >> 1);
   assign covered = (l_ff <= cur_ff.lo) && (cur_ff.hi <= r_ff);
   assign push_l  = (l_ff <= mid);
   assign push_r  = (r_ff > mid);
   assign n_post  = (kind_ff == REQ_ADD);   // only adds recombine
   assign len_l   = SPAN_W'(mid) - SPAN_W'(cur_ff.lo) + SPAN_W'(1);
   assign len_r   = SPAN_W'(cur_ff.hi) - SPAN_W'(mid);
   assign len_all = SPAN_W'(cur_ff.hi) - SPAN_W'(cur_ff.lo) + SPAN_W'(1);
   assign lchild  = {cur_ff.node[NODE_W-2:0], 1'b0};
   assign rchild  = {cur_ff.node[NODE_W-2:0], 1'b1};

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_range_sum = out_ff;

   // Stack: recombine frame at the bottom, then right, then left on top.
   assign top   = stack_ff[sp_ff - SP_W'(1)];
   assign fpost = '{post: 1'b1, node: cur_ff.node, lo: cur_ff.lo, hi: cur_ff.hi};
   assign fl    = '{post: 1'b0, node: lchild, lo: cur_ff.lo, hi: mid};
   assign fr    = '{post: 1'b0, node: rchild, lo: mid + idx_type'(1), hi: cur_ff.hi};
   assign sp_right = sp_ff + SP_W'(n_post);
   assign sp_left  = sp_right + SP_W'(push_r);

   always_comb begin
      mreq     = '0;
      state_in = state_ff;
      sp_in    = sp_ff;
      cur_in   = cur_ff;
      clr_in   = clr_ff;
      acc_in   = acc_ff;
      tag_in   = tag_ff;
      lsum_in  = lsum_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mreq.wr   = 1'b1;
            mreq.addr = clr_ff;
            clr_in    = clr_ff + node_type'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               acc_in = '0;
               if (req_left <= r_clip) begin
                  cur_in    = '{post: 1'b0, node: node_type'(1), lo: '0,
                                hi: idx_type'(LEAVES-1)};
                  mreq.rd   = 1'b1;
                  mreq.addr = node_type'(1);
                  state_in  = S_EVAL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cur_in  = top;
               sp_in   = sp_ff - SP_W'(1);
               mreq.rd = 1'b1;
               if (top.post) begin
                  // recombine: left child first, right child next cycle
                  mreq.addr = {top.node[NODE_W-2:0], 1'b0};
                  state_in  = S_LSUM;
               end else begin
                  mreq.addr = top.node;
                  state_in  = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (covered) begin
               if (kind_ff == REQ_ADD) begin
                  mreq.wr     = 1'b1;
                  mreq.addr   = cur_ff.node;
                  mreq.sum_wr = sum_rd + scale(val_ff, len_all);
                  mreq.tag_wr = tag_rd + val_ff;
               end else begin
                  acc_in = acc_ff + sum_rd;
               end
               state_in = S_POP;
            end else if (tag_rd != '0) begin
               // clear own tag; the children get it in S_PDLR, S_PDLW, S_PDRR and S_PDRW
               mreq.wr     = 1'b1;
               mreq.addr   = cur_ff.node;
               mreq.sum_wr = sum_rd;
               mreq.tag_wr = '0;
               tag_in      = tag_rd;
               state_in    = S_PDLR;
            end else begin
               state_in = S_SCHED;
            end
         end
         S_PDLR: begin
            mreq.rd   = 1'b1;
            mreq.addr = lchild;
            state_in  = S_PDLW;
         end
         S_PDLW: begin
            mreq.wr     = 1'b1;
            mreq.addr   = lchild;
            mreq.sum_wr = sum_rd + scale(tag_ff, len_l);
            mreq.tag_wr = tag_rd + tag_ff;
            state_in    = S_PDRR;
         end
         S_PDRR: begin
            mreq.rd   = 1'b1;
            mreq.addr = rchild;
            state_in  = S_PDRW;
         end
         S_PDRW: begin
            mreq.wr     = 1'b1;
            mreq.addr   = rchild;
            mreq.sum_wr = sum_rd + scale(tag_ff, len_r);
            mreq.tag_wr = tag_rd + tag_ff;
            state_in    = S_SCHED;
         end
         S_SCHED: begin
            sp_in    = sp_left + SP_W'(push_l);
            state_in = S_POP;
         end
         S_LSUM: begin
            lsum_in   = sum_rd;
            mreq.rd   = 1'b1;
            mreq.addr = rchild;
            state_in  = S_COMB;
         end
         S_COMB: begin
            mreq.wr     = 1'b1;
            mreq.addr   = cur_ff.node;
            mreq.sum_wr = lsum_ff + sum_rd;
            mreq.tag_wr = '0;    // tag was cleared on the way down
            state_in    = S_POP;
         end
         S_DONE: begin
            if (kind_ff == REQ_ADD || !out_v_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: loads when a sum ends and the slot is free or draining.
   assign load_out = (state_ff == S_DONE) && (kind_ff == REQ_SUM) &&
                     (!out_v_ff || !rsp_stall);
   assign out_v_in = load_out || (out_v_ff && rsp_stall);
   assign out_in   = load_out ? acc_ff : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sp_ff    <= '0;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         clr_ff   <= clr_in;
         out_v_ff <= out_v_in;
      end
   end

   // Walk data and payload registers.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      tag_ff  <= tag_in;
      lsum_ff <= lsum_in;
      out_ff  <= out_in;
      if (accept) begin
         kind_ff <= req_req_type;
         l_ff    <= req_left;
         r_ff    <= r_clip;
         val_ff  <= req_value;
      end
   end

   // Stack frames pushed when scheduling children.
   always_ff @(posedge clock) begin
      if (state_ff == S_SCHED) begin
         if (n_post) begin
            stack_ff[sp_ff] <= fpost;
         end
         if (push_r) begin
            stack_ff[sp_right] <= fr;
         end
         if (push_l) begin
            stack_ff[sp_left] <= fl;
         end
      end
   end

`ifndef SYNTHESIS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_D)) else $error("walk stack overflow");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept) else $error("accept while busy");
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && &clr_ff) |=> (state_ff == S_IDLE))
      else $error("clear pass did not end");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_range_sum)))
      else $error("stalled result changed");
`endif

endmodule
